// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the block table fit allocator
// Field widths, action, strategy and status codes, and the control and
// status structs that pass between the sequencer and the fit unit.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ACTION_W = 2;
  localparam int STRAT_W  = 2;
  localparam int REQ_W    = 16;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 3;

  // Action codes; the fourth code is a no-op that answers "not found".
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

  // Fit rules. Every code other than these two selects first-fit.
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd5;

  typedef struct packed {
    logic clear;   // start of a new scan
    logic sample;  // table read data is valid this cycle
  } fit_ctl_t;

  typedef struct packed {
    logic pick_found;  // a valid, free entry fits the request
    logic hole_found;  // an invalid entry was seen
  } fit_sts_t;

endpackage

// ===== rtl/bfa_table_mem.sv =====
// ----------------------------------------------------------------------------
// bfa_table_mem: block table storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bfa_fit_unit.sv =====
// ----------------------------------------------------------------------------
// bfa_fit_unit: running fit selection over a table scan
// Looks at one table entry per cycle while ctl.sample is set and keeps the best
// candidate so far under the chosen fit rule, plus the lowest invalid entry.
// ----------------------------------------------------------------------------
module bfa_fit_unit #(
  parameter int MAX_ENTRIES = 64,
  parameter int SIZE_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfa_pkg::fit_ctl_t              ctl,
  input  logic [bfa_pkg::STRAT_W-1:0]    strategy,
  input  logic [SIZE_BITS-1:0]           req_size,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rd_idx,
  input  logic                           rd_valid,
  input  logic                           rd_in_use,
  input  logic [SIZE_BITS-1:0]           rd_size,
  output bfa_pkg::fit_sts_t              sts,
  output logic [$clog2(MAX_ENTRIES)-1:0] pick_idx,
  output logic [SIZE_BITS-1:0]           pick_size,
  output logic [$clog2(MAX_ENTRIES)-1:0] hole_idx
);
  import bfa_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  logic            pick_vld_r;
  logic            hole_vld_r;
  logic [AW-1:0]   pick_idx_r;
  logic [SIZE_BITS-1:0] pick_size_r;
  logic [AW-1:0]   hole_idx_r;
  logic            fits;
  logic            take;
  logic            take_hole;

  always_comb begin
    fits = rd_valid && !rd_in_use && (rd_size >= req_size);
    // Strict compares keep the lowest index on ties.
    take = fits && (!pick_vld_r ||
                    ((strategy == STRAT_BEST)  && (rd_size < pick_size_r)) ||
                    ((strategy == STRAT_WORST) && (rd_size > pick_size_r)));
    take_hole = !rd_valid && !hole_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_vld_r <= 1'b0;
      hole_vld_r <= 1'b0;
    end else if (ctl.clear) begin
      pick_vld_r <= 1'b0;
      hole_vld_r <= 1'b0;
    end else if (ctl.sample) begin
      if (take) begin
        pick_vld_r  <= 1'b1;
        pick_idx_r  <= rd_idx;
        pick_size_r <= rd_size;
      end
      if (take_hole) begin
        hole_vld_r <= 1'b1;
        hole_idx_r <= rd_idx;
      end
    end
  end

  assign sts.pick_found = pick_vld_r;
  assign sts.hole_found = hole_vld_r;
  assign pick_idx       = pick_idx_r;
  assign pick_size      = pick_size_r;
  assign hole_idx       = hole_idx_r;

endmodule

// ===== rtl/block_table_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// block_table_fit_allocator: table-based first/best/worst fit allocator
// Steps: a load writes its entry on accept; a free reads the entry, then clears
// in_use if it is valid and in use; an allocate issues one table read per cycle
// over every entry, then commits. One transaction at a time: the next input is
// taken only once the result has been handed to the output register.
// Reset: synchronous, active low; afterwards a clearing pass invalidates
// every table entry, during which in_ready stays low.
// ----------------------------------------------------------------------------
module block_table_fit_allocator #(
  parameter int MAX_ENTRIES = 64,
  parameter int SIZE_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bfa_pkg::ACTION_W-1:0]     in_action,
  input  logic [bfa_pkg::STRAT_W-1:0]      in_strategy,
  input  logic [bfa_pkg::REQ_W-1:0]        in_request_size,
  input  logic [bfa_pkg::ID_W-1:0]         in_entry_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bfa_pkg::STATUS_W-1:0]     out_status,
  output logic [bfa_pkg::ID_W-1:0]         out_granted_id
);
  import bfa_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = SIZE_BITS + 2;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);

  // Each table word holds {valid, in_use, size}.
  localparam int V_BIT = EW - 1;
  localparam int U_BIT = EW - 2;

  typedef enum logic [2:0] {
    S_CLEAR,     // post-reset invalidation pass
    S_IDLE,      // waiting for an input transaction
    S_SCAN,      // allocate: issuing one table read per cycle
    S_DRAIN,     // allocate: last read data lands in the fit unit
    S_COMMIT,    // allocate: write back the chosen entry
    S_FREE_CHK,  // free: check the entry read back and clear in_use
    S_FINISH     // hand the result to the output register
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        addr_r;
  logic                 rd_tag_r;
  logic [AW-1:0]        rd_idx_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [STRAT_W-1:0]   strat_r;
  logic [AW-1:0]        id_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [ID_W-1:0]      res_granted_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ID_W-1:0]      out_granted_r;

  logic                 in_accept;
  logic                 id_in_range;
  logic [SIZE_BITS-1:0] req_in;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [EW-1:0]        mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [EW-1:0]        mem_rd_data;

  fit_ctl_t             fit_ctl;
  fit_sts_t             fit_sts;
  logic [AW-1:0]        pick_idx;
  logic [SIZE_BITS-1:0] pick_size;
  logic [AW-1:0]        hole_idx;

  assign in_ready    = (state_r == S_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign id_in_range = (32'(in_entry_id) < MAX_ENTRIES);
  // Request size is taken modulo 2^SIZE_BITS, or zero-extended when wider.
  assign req_in      = SIZE_BITS'(in_request_size);

  // The fit unit restarts on every accepted transaction and samples read
  // data in the cycle after each scan read.
  assign fit_ctl.clear  = in_accept;
  assign fit_ctl.sample = rd_tag_r;

  bfa_table_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bfa_fit_unit #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fit_ctl),
    .strategy  (strat_r),
    .req_size  (req_r),
    .rd_idx    (rd_idx_r),
    .rd_valid  (mem_rd_data[V_BIT]),
    .rd_in_use (mem_rd_data[U_BIT]),
    .rd_size   (mem_rd_data[SIZE_BITS-1:0]),
    .sts       (fit_sts),
    .pick_idx  (pick_idx),
    .pick_size (pick_size),
    .hole_idx  (hole_idx)
  );

  // Table port control. Only one transaction is in flight, so a write-back
  // always completes before the next transaction reads the table.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = addr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      S_IDLE: begin
        if (in_accept && id_in_range && (in_action == ACT_LOAD)) begin
          // A load leaves the entry valid and free, even if it was in use.
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(in_entry_id);
          mem_wr_data = {1'b1, 1'b0, req_in};
        end
        if (in_accept && id_in_range && (in_action == ACT_FREE)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(in_entry_id);
        end
      end
      S_SCAN: begin
        mem_rd_en = 1'b1;
      end
      S_DRAIN: ;
      S_COMMIT: begin
        if (fit_sts.pick_found) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pick_idx;
          mem_wr_data = {1'b1, 1'b1, pick_size};
        end else if (fit_sts.hole_found) begin
          // Nothing fits: the lowest invalid entry takes the exact request.
          mem_wr_en   = 1'b1;
          mem_wr_addr = hole_idx;
          mem_wr_data = {1'b1, 1'b1, req_r};
        end
      end
      S_FREE_CHK: begin
        if (mem_rd_data[V_BIT] && mem_rd_data[U_BIT]) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = id_r;
          mem_wr_data = {1'b1, 1'b0, mem_rd_data[SIZE_BITS-1:0]};
        end
      end
      S_FINISH: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      rd_tag_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_tag_r <= (state_r == S_SCAN);
      rd_idx_r <= addr_r;
      // In S_FINISH the output register is refilled below whenever it drains.
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (addr_r == LAST_IDX) begin
            addr_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r         <= req_in;
            strat_r       <= in_strategy;
            id_r          <= AW'(in_entry_id);
            res_granted_r <= '0;
            unique case (in_action)
              ACT_LOAD: begin
                res_status_r <= ST_LOADED;
                state_r      <= S_FINISH;
              end
              ACT_ALLOC: begin
                addr_r  <= '0;
                state_r <= S_SCAN;
              end
              ACT_FREE: begin
                res_status_r <= ST_NOT_FOUND;
                state_r      <= id_in_range ? S_FREE_CHK : S_FINISH;
              end
              default: begin
                res_status_r <= ST_NOT_FOUND;
                state_r      <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (addr_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (fit_sts.pick_found) begin
            res_status_r  <= ST_FIT;
            res_granted_r <= ID_W'(pick_idx);
          end else if (fit_sts.hole_found) begin
            res_status_r  <= ST_APPENDED;
            res_granted_r <= ID_W'(hole_idx);
          end else begin
            res_status_r  <= ST_FULL;
            res_granted_r <= '0;
          end
          state_r <= S_FINISH;
        end
        S_FREE_CHK: begin
          res_status_r <= (mem_rd_data[V_BIT] && mem_rd_data[U_BIT]) ?
                          ST_FREED : ST_NOT_FOUND;
          state_r      <= S_FINISH;
        end
        S_FINISH: begin
          // Wait here until the output register is empty or being drained.
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_granted_r <= res_granted_r;
            state_r       <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_granted_id = out_granted_r;

endmodule

// ===== rtl/bfa_checker.sv =====
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks for the block table fit allocator
// Watches the top-level ports only and is attached with a bind statement.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bfa_pkg::ACTION_W-1:0] in_action,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bfa_pkg::STATUS_W-1:0] out_status,
  input logic [bfa_pkg::ID_W-1:0]     out_granted_id
);
  import bfa_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_granted_id))
    else $error("result changed while stalled");

  // Only allocate grants carry a nonzero id.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FIT) && (out_status != ST_APPENDED)
    |-> (out_granted_id == '0))
    else $error("nonzero granted id on a non-grant status");

  // One transaction at a time: input is blocked right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // Status codes beyond the defined set never appear.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_LOADED))
    else $error("undefined status code");

  // Reset empties the output and starts the clearing pass.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output valid or input ready right after reset");

endmodule

bind block_table_fit_allocator bfa_checker u_bfa_checker (.*);
